// ----- rtl/qbc_pkg.sv -----
// ----------------------------------------------------------------------------
// qbc_pkg
// Shared types and constants for the quiz buzzer controller: event codes,
// alarm codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package qbc_pkg;

    localparam int NUM_PLAYERS = 8;

    localparam int FUNC_W    = 3;
    localparam int PLAYER_W  = 4;
    localparam int TENS_W    = 3;
    localparam int ONES_W    = 4;
    localparam int TPS_W     = 8;
    localparam int ALARM_W   = 16;
    localparam int TONE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Event codes
    localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SHORT_CLR  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LONG_CLR   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PLAYER_KEY = 3'd4;

    // Alarm kinds
    localparam logic [1:0] ALARM_SILENT  = 2'd0;
    localparam logic [1:0] ALARM_TIMEOUT = 2'd1;
    localparam logic [1:0] ALARM_ANSWER  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANSWER_ALARM_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TONE_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANSWER_TONE_LIMIT  = 2'd3;

    // Register reset values
    localparam logic [TPS_W-1:0]   TPS_RESET          = 8'd100;
    localparam logic [ALARM_W-1:0] ANSWER_TICKS_RESET = 16'd1000;
    localparam logic [TONE_W-1:0]  TIMEOUT_TONE_RESET = 8'h10;
    localparam logic [TONE_W-1:0]  ANSWER_TONE_RESET  = 8'h20;

    // Countdown digit limits
    localparam logic [TENS_W-1:0] PRESET_TENS_RESET = 3'd3;
    localparam logic [TENS_W-1:0] TENS_MAX          = 3'd5;
    localparam logic [ONES_W-1:0] ONES_MAX          = 4'd9;

    localparam logic [PLAYER_W-1:0] MAX_PLAYER = PLAYER_W'(NUM_PLAYERS);

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [PLAYER_W-1:0] player;
    } event_t;

    typedef struct packed {
        logic [TENS_W-1:0]   seconds_tens;
        logic [ONES_W-1:0]   seconds_ones;
        logic [PLAYER_W-1:0] winner;
        logic                set_mode;
        logic                round_running;
        logic                timed_out;
        logic                buzzer;
    } status_t;

endpackage

// ----- rtl/qbc_channels.sv -----
// ----------------------------------------------------------------------------
// qbc channels
// Valid/ready channel interfaces for the quiz buzzer event input and the
// status output.
// ----------------------------------------------------------------------------
interface qbc_in_if;
    logic                       valid;
    logic                       ready;
    logic [qbc_pkg::FUNC_W-1:0]   func;
    logic [qbc_pkg::PLAYER_W-1:0] player;

    modport source (output valid, output func, output player, input ready);
    modport sink   (input valid, input func, input player, output ready);
endinterface

interface qbc_out_if;
    logic                         valid;
    logic                         ready;
    logic [qbc_pkg::TENS_W-1:0]   seconds_tens;
    logic [qbc_pkg::ONES_W-1:0]   seconds_ones;
    logic [qbc_pkg::PLAYER_W-1:0] winner;
    logic                         set_mode;
    logic                         round_running;
    logic                         timed_out;
    logic                         buzzer;

    modport source (output valid, output seconds_tens, output seconds_ones,
                    output winner, output set_mode, output round_running,
                    output timed_out, output buzzer, input ready);
    modport sink   (input valid, input seconds_tens, input seconds_ones,
                    input winner, input set_mode, input round_running,
                    input timed_out, input buzzer, output ready);
endinterface

// ----- rtl/quiz_buzzer_controller.sv -----
// ----------------------------------------------------------------------------
// quiz_buzzer_controller
// Eight-player quiz buzzer with a BCD seconds countdown and alarm tones.
// ----------------------------------------------------------------------------
// Usage:
// Events (tick, start, short clear, long clear, player key) arrive on in_ch;
// each transaction yields exactly one status transaction on out_ch carrying
// the countdown digits, the winner, the mode flags and the buzzer level.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must write them only while the block is idle, which the block itself
// leaves unchecked. They take effect on the next event.
// An accepted event is captured in an input register, processed once the
// output register is free, and its status is presented from the output
// register. One event can be accepted every cycle while out_ch takes each
// status; the state update is a single pass of counter logic.
// When out_ch stalls, the output register holds and the input register
// fills; in_ch.ready drops only when both are occupied.
// Reset clears the flags, counters and the winner, loads the preset and
// count with 30 seconds and restores the register defaults.
// ----------------------------------------------------------------------------
module quiz_buzzer_controller
(
    input  logic                            clk,
    input  logic                            rst_n,
    qbc_in_if.sink                          in_ch,
    qbc_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [qbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qbc_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
    import qbc_pkg::*;

    // Configuration
    logic [TPS_W-1:0]   tps_reg;
    logic [ALARM_W-1:0] answer_ticks_reg;
    logic [TONE_W-1:0]  timeout_tone_reg;
    logic [TONE_W-1:0]  answer_tone_reg;

    // Input stage
    logic   in_valid_reg;
    event_t in_event_reg;

    // Output stage
    logic    out_valid_reg;
    status_t out_status_reg;

    // Block state
    logic               mode_reg, mode_next;
    logic               running_reg, running_next;
    logic               timeout_reg, timeout_next;
    logic [1:0]         alarm_kind_reg, alarm_kind_next;
    logic [TENS_W-1:0]  preset_tens_reg, preset_tens_next;
    logic [ONES_W-1:0]  preset_ones_reg, preset_ones_next;
    logic [TENS_W-1:0]  count_tens_reg, count_tens_next;
    logic [ONES_W-1:0]  count_ones_reg, count_ones_next;
    logic [TPS_W-1:0]   sec_div_reg, sec_div_next;
    logic [TONE_W-1:0]  tone_div_reg, tone_div_next;
    logic [TONE_W-1:0]  tone_limit_reg, tone_limit_next;
    logic [ALARM_W-1:0] elapsed_reg, elapsed_next;
    logic               buzzer_reg, buzzer_next;
    logic [PLAYER_W-1:0] winner_reg, winner_next;

    logic advance;
    logic tone_step;
    logic [TPS_W-1:0] sec_top;
    status_t status_next;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign sec_top     = tps_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg          <= TPS_RESET;
            answer_ticks_reg <= ANSWER_TICKS_RESET;
            timeout_tone_reg <= TIMEOUT_TONE_RESET;
            answer_tone_reg  <= ANSWER_TONE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TICKS_PER_SECOND:   tps_reg          <= cfg_wdata[TPS_W-1:0];
                REG_ANSWER_ALARM_TICKS: answer_ticks_reg <= cfg_wdata[ALARM_W-1:0];
                REG_TIMEOUT_TONE_LIMIT: timeout_tone_reg <= cfg_wdata[TONE_W-1:0];
                REG_ANSWER_TONE_LIMIT:  answer_tone_reg  <= cfg_wdata[TONE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_event_reg.func   <= in_ch.func;
            in_event_reg.player <= in_ch.player;
        end
    end

    // Event processing: one pass from the current state to the next.
    always_comb
    begin
        mode_next        = mode_reg;
        running_next     = running_reg;
        timeout_next     = timeout_reg;
        alarm_kind_next  = alarm_kind_reg;
        preset_tens_next = preset_tens_reg;
        preset_ones_next = preset_ones_reg;
        count_tens_next  = count_tens_reg;
        count_ones_next  = count_ones_reg;
        sec_div_next     = sec_div_reg;
        tone_div_next    = tone_div_reg;
        tone_limit_next  = tone_limit_reg;
        elapsed_next     = elapsed_reg;
        buzzer_next      = buzzer_reg;
        winner_next      = winner_reg;
        tone_step        = 1'b0;

        case (in_event_reg.func)
            FUNC_TICK:
            begin
                case (alarm_kind_reg)
                    ALARM_TIMEOUT:
                    begin
                        tone_step = 1'b1;
                    end
                    ALARM_ANSWER:
                    begin
                        if (elapsed_reg < answer_ticks_reg)
                        begin
                            elapsed_next = elapsed_reg + 1'b1;
                            tone_step    = 1'b1;
                        end
                        else
                        begin
                            alarm_kind_next = ALARM_SILENT;
                            elapsed_next    = '0;
                        end
                    end
                    default:
                    begin
                        buzzer_next = 1'b0;
                    end
                endcase

                if (tone_step)
                begin
                    if (tone_div_reg < tone_limit_reg)
                    begin
                        tone_div_next = tone_div_reg + 1'b1;
                    end
                    else
                    begin
                        tone_div_next = '0;
                        buzzer_next   = !buzzer_reg;
                    end
                end

                if (running_reg)
                begin
                    if (sec_div_reg < sec_top)
                    begin
                        sec_div_next = sec_div_reg + 1'b1;
                    end
                    else
                    begin
                        sec_div_next = '0;
                        if (count_ones_reg != '0)
                        begin
                            count_ones_next = count_ones_reg - 1'b1;
                        end
                        else if (count_tens_reg != '0)
                        begin
                            count_ones_next = ONES_MAX;
                            count_tens_next = count_tens_reg - 1'b1;
                        end
                        else
                        begin
                            timeout_next = 1'b1;
                        end
                    end
                end
            end

            FUNC_START:
            begin
                if (!mode_reg)
                begin
                    if (!running_reg)
                    begin
                        count_tens_next = preset_tens_reg;
                        count_ones_next = preset_ones_reg;
                        winner_next     = '0;
                        running_next    = 1'b1;
                    end
                end
                else
                begin
                    if (preset_ones_reg < ONES_MAX)
                    begin
                        preset_ones_next = preset_ones_reg + 1'b1;
                    end
                    else
                    begin
                        preset_ones_next = '0;
                        preset_tens_next = (preset_tens_reg < TENS_MAX) ?
                                           preset_tens_reg + 1'b1 : '0;
                    end
                    count_tens_next = preset_tens_next;
                    count_ones_next = preset_ones_next;
                end
            end

            FUNC_SHORT_CLR, FUNC_LONG_CLR:
            begin
                if (mode_reg)
                begin
                    mode_next = 1'b0;
                end
                else if ((in_event_reg.func == FUNC_LONG_CLR) && !running_reg)
                begin
                    mode_next = 1'b1;
                end
                running_next    = 1'b0;
                timeout_next    = 1'b0;
                alarm_kind_next = ALARM_SILENT;
                count_tens_next = preset_tens_reg;
                count_ones_next = preset_ones_reg;
                winner_next     = '0;
            end

            FUNC_PLAYER_KEY:
            begin
                if (running_reg && !timeout_reg && (in_event_reg.player != '0)
                    && (in_event_reg.player <= MAX_PLAYER))
                begin
                    running_next    = 1'b0;
                    tone_limit_next = answer_tone_reg;
                    alarm_kind_next = ALARM_ANSWER;
                    elapsed_next    = '0;
                    winner_next     = in_event_reg.player;
                end
            end

            default: ;
        endcase

        // A running round that timed out keeps the timeout tone going.
        if (running_next && timeout_next)
        begin
            alarm_kind_next = ALARM_TIMEOUT;
            tone_limit_next = timeout_tone_reg;
        end

        status_next.seconds_tens  = count_tens_next;
        status_next.seconds_ones  = count_ones_next;
        status_next.winner        = winner_next;
        status_next.set_mode      = mode_next;
        status_next.round_running = running_next;
        status_next.timed_out     = timeout_next;
        status_next.buzzer        = buzzer_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            running_reg     <= 1'b0;
            timeout_reg     <= 1'b0;
            alarm_kind_reg  <= ALARM_SILENT;
            preset_tens_reg <= PRESET_TENS_RESET;
            preset_ones_reg <= '0;
            count_tens_reg  <= PRESET_TENS_RESET;
            count_ones_reg  <= '0;
            sec_div_reg     <= '0;
            tone_div_reg    <= '0;
            tone_limit_reg  <= '0;
            elapsed_reg     <= '0;
            buzzer_reg      <= 1'b0;
            winner_reg      <= '0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            running_reg     <= running_next;
            timeout_reg     <= timeout_next;
            alarm_kind_reg  <= alarm_kind_next;
            preset_tens_reg <= preset_tens_next;
            preset_ones_reg <= preset_ones_next;
            count_tens_reg  <= count_tens_next;
            count_ones_reg  <= count_ones_next;
            sec_div_reg     <= sec_div_next;
            tone_div_reg    <= tone_div_next;
            tone_limit_reg  <= tone_limit_next;
            elapsed_reg     <= elapsed_next;
            buzzer_reg      <= buzzer_next;
            winner_reg      <= winner_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.seconds_tens  = out_status_reg.seconds_tens;
    assign out_ch.seconds_ones  = out_status_reg.seconds_ones;
    assign out_ch.winner        = out_status_reg.winner;
    assign out_ch.set_mode      = out_status_reg.set_mode;
    assign out_ch.round_running = out_status_reg.round_running;
    assign out_ch.timed_out     = out_status_reg.timed_out;
    assign out_ch.buzzer        = out_status_reg.buzzer;

`ifndef SYNTH
    // A running round never has a winner; locking stops the round.
    a_run_no_winner: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (winner_reg == '0))
        else $error("round running with a winner recorded");

    a_timeout_running: assert property (@(posedge clk) disable iff (!rst_n)
        timeout_reg |-> running_reg)
        else $error("timeout flag set outside a running round");

    a_setmode_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg |-> !running_reg)
        else $error("round running in set mode");

    a_bcd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_tens_reg <= TENS_MAX) && (count_ones_reg <= ONES_MAX)
        && (preset_tens_reg <= TENS_MAX) && (preset_ones_reg <= ONES_MAX))
        else $error("countdown digits out of BCD range");
`endif

endmodule

// ----- tb/sv/tb_quiz_buzzer_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quiz_buzzer_controller
// Self-checking bench for the quiz buzzer controller. A scoreboard class
// keeps its own copy of the countdown, alarm and mode state. It works out
// the status that each accepted event should produce and compares that
// status, field by field, with each status transaction the block returns.
// Stimulus runs a short directed sequence and then random quiz rounds over
// several register settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_quiz_buzzer_controller;
    import qbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int RANDOM_PHASES = 7;
    localparam int ROUND_TICK_CAP = 260;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    class buzzer_scoreboard;
        logic [TPS_W-1:0]    tick_rate;
        logic [ALARM_W-1:0]  answer_len;
        logic [TONE_W-1:0]   timeout_pitch;
        logic [TONE_W-1:0]   answer_pitch;
        logic                in_setting;
        logic                armed;
        logic                expired;
        logic [1:0]          alarm;
        logic [TENS_W-1:0]   preset_t;
        logic [ONES_W-1:0]   preset_o;
        logic [TENS_W-1:0]   count_t;
        logic [ONES_W-1:0]   count_o;
        logic [TPS_W-1:0]    sec_div;
        logic [TONE_W-1:0]   tone_div;
        logic [TONE_W-1:0]   tone_lim;
        logic [ALARM_W-1:0]  elapsed;
        logic                buzz;
        logic [PLAYER_W-1:0] winner;
        status_t             pending_status[$];
        int unsigned         events;
        int unsigned         checked;
        int unsigned         mismatches;
        int unsigned         timeouts;
        int unsigned         locks;

        function new();
            tick_rate     = TPS_RESET;
            answer_len    = ANSWER_TICKS_RESET;
            timeout_pitch = TIMEOUT_TONE_RESET;
            answer_pitch  = ANSWER_TONE_RESET;
            in_setting    = 1'b0;
            armed         = 1'b0;
            expired       = 1'b0;
            alarm         = ALARM_SILENT;
            preset_t      = PRESET_TENS_RESET;
            preset_o      = '0;
            count_t       = PRESET_TENS_RESET;
            count_o       = '0;
            sec_div       = '0;
            tone_div      = '0;
            tone_lim      = '0;
            elapsed       = '0;
            buzz          = 1'b0;
            winner        = '0;
            events        = 0;
            checked       = 0;
            mismatches    = 0;
            timeouts      = 0;
            locks         = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_TICKS_PER_SECOND:   tick_rate = data[TPS_W-1:0];
                REG_ANSWER_ALARM_TICKS: answer_len = data[ALARM_W-1:0];
                REG_TIMEOUT_TONE_LIMIT: timeout_pitch = data[TONE_W-1:0];
                REG_ANSWER_TONE_LIMIT:  answer_pitch = data[TONE_W-1:0];
                default: ;
            endcase
        endfunction

        function void tone_step();
            if (tone_div < tone_lim)
                tone_div = tone_div + 1'b1;
            else
            begin
                tone_div = '0;
                buzz = ~buzz;
            end
        endfunction

        function void tick();
            logic [TPS_W-1:0] top;
            case (alarm)
                ALARM_TIMEOUT: tone_step();
                ALARM_ANSWER:
                begin
                    if (elapsed < answer_len)
                    begin
                        elapsed = elapsed + 1'b1;
                        tone_step();
                    end
                    else
                    begin
                        alarm = ALARM_SILENT;
                        elapsed = '0;
                    end
                end
                default: buzz = 1'b0;
            endcase
            if (armed)
            begin
                // A rate of one gives a top of zero, so every tick is a second.
                top = tick_rate - 1'b1;
                if (sec_div < top)
                    sec_div = sec_div + 1'b1;
                else
                begin
                    sec_div = '0;
                    if (count_o > 0)
                        count_o = count_o - 1'b1;
                    else if (count_t != 0)
                    begin
                        count_o = ONES_MAX;
                        count_t = count_t - 1'b1;
                    end
                    else
                    begin
                        if (!expired)
                            timeouts++;
                        expired = 1'b1;
                    end
                end
            end
        endfunction

        function void clear(bit long_press);
            if (in_setting)
                in_setting = 1'b0;
            else if (long_press && !armed)
                in_setting = 1'b1;
            armed   = 1'b0;
            expired = 1'b0;
            alarm   = ALARM_SILENT;
            count_t = preset_t;
            count_o = preset_o;
            winner  = '0;
        endfunction

        function void note_event(event_t ev);
            status_t exp;
            events++;
            case (ev.func)
                FUNC_TICK: tick();
                FUNC_START:
                begin
                    if (!in_setting)
                    begin
                        if (!armed)
                        begin
                            count_t = preset_t;
                            count_o = preset_o;
                            winner  = '0;
                            armed   = 1'b1;
                        end
                    end
                    else
                    begin
                        if (preset_o < ONES_MAX)
                            preset_o = preset_o + 1'b1;
                        else
                        begin
                            preset_o = '0;
                            preset_t = (preset_t < TENS_MAX) ? preset_t + 1'b1 : '0;
                        end
                        count_t = preset_t;
                        count_o = preset_o;
                    end
                end
                FUNC_SHORT_CLR: clear(1'b0);
                FUNC_LONG_CLR:  clear(1'b1);
                FUNC_PLAYER_KEY:
                begin
                    if (armed && !expired && ev.player >= 1 && ev.player <= MAX_PLAYER)
                    begin
                        armed    = 1'b0;
                        tone_lim = answer_pitch;
                        alarm    = ALARM_ANSWER;
                        elapsed  = '0;
                        winner   = ev.player;
                        locks++;
                    end
                end
                default: ;
            endcase
            if (armed && expired)
            begin
                alarm    = ALARM_TIMEOUT;
                tone_lim = timeout_pitch;
            end
            exp.seconds_tens  = count_t;
            exp.seconds_ones  = count_o;
            exp.winner        = winner;
            exp.set_mode      = in_setting;
            exp.round_running = armed;
            exp.timed_out     = expired;
            exp.buzzer        = buzz;
            pending_status.push_back(exp);
        endfunction

        function string show(status_t s);
            return $sformatf("tens=%0d ones=%0d winner=%0d set=%0b run=%0b tmo=%0b buzz=%0b",
                             s.seconds_tens, s.seconds_ones, s.winner, s.set_mode,
                             s.round_running, s.timed_out, s.buzzer);
        endfunction

        function void check_status(status_t got);
            status_t exp;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] status with no event pending: %s", $realtime, show(got));
                return;
            end
            exp = pending_status.pop_front();
            checked++;
            if (got.seconds_tens !== exp.seconds_tens || got.seconds_ones !== exp.seconds_ones
                || got.winner !== exp.winner || got.set_mode !== exp.set_mode
                || got.round_running !== exp.round_running
                || got.timed_out !== exp.timed_out || got.buzzer !== exp.buzzer)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] status #%0d expected %s got %s", $realtime, checked,
                             show(exp), show(got));
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    qbc_in_if  in_ch();
    qbc_out_if out_ch();

    quiz_buzzer_controller uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    buzzer_scoreboard sb;
    status_t          seen_status;
    int unsigned      quiet_cycles;
    int unsigned      settings_used;
    bit               sender_burst;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            seen_status.seconds_tens  = out_ch.seconds_tens;
            seen_status.seconds_ones  = out_ch.seconds_ones;
            seen_status.winner        = out_ch.winner;
            seen_status.set_mode      = out_ch.set_mode;
            seen_status.round_running = out_ch.round_running;
            seen_status.timed_out     = out_ch.timed_out;
            seen_status.buzzer        = out_ch.buzzer;
            sb.check_status(seen_status);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                 || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("quiz_buzzer_controller: mismatch");
        $finish;
    end

    // Status receiver: random stalls, with occasional stretches of none.
    initial
    begin
        int unsigned stall;
        int unsigned burst_left;
        out_ch.ready = 1'b0;
        burst_left = 0;
        @(posedge rst_n);
        forever
        begin
            if (burst_left > 0)
            begin
                burst_left--;
                stall = 0;
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    burst_left = $urandom_range(10, 40);
                stall = $urandom_range(0, 15);
            end
            repeat (stall)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_event(logic [FUNC_W-1:0] f, logic [PLAYER_W-1:0] p);
        int unsigned gap;
        event_t      ev;
        if ($urandom_range(0, 199) == 0)
            wait_drained();
        gap = sender_burst ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid  <= 1'b1;
        in_ch.func   <= f;
        in_ch.player <= p;
        do
            @(posedge clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        // Noting here keeps the scoreboard current before the next decision.
        ev.func   = f;
        ev.player = p;
        sb.note_event(ev);
    endtask

    task automatic send_noise();
        send_event(FUNC_W'($urandom_range(0, 7)), PLAYER_W'($urandom_range(0, 15)));
    endtask

    task automatic program_regs(logic [CFG_DAT_W-1:0] tps, logic [CFG_DAT_W-1:0] ans,
                                logic [CFG_DAT_W-1:0] tlim, logic [CFG_DAT_W-1:0] alim);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DAT_W-1:0] val [4];
        idx = '{REG_TICKS_PER_SECOND, REG_ANSWER_ALARM_TICKS,
                REG_TIMEOUT_TONE_LIMIT, REG_ANSWER_TONE_LIMIT};
        val = '{tps, ans, tlim, alim};
        wait_drained();
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            sb.set_reg(idx[i], val[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_directed();
        event_t seq [28];
        seq = '{
            '{FUNC_TICK, 4'd0},       '{FUNC_START, 4'd15},     '{FUNC_TICK, 4'd0},
            '{FUNC_TICK, 4'd7},       '{FUNC_PLAYER_KEY, 4'd0}, '{FUNC_PLAYER_KEY, 4'd9},
            '{FUNC_PLAYER_KEY, 4'd15}, '{FUNC_START, 4'd0},     '{FUNC_PLAYER_KEY, 4'd1},
            '{FUNC_PLAYER_KEY, 4'd8}, '{FUNC_TICK, 4'd0},       '{FUNC_TICK, 4'd0},
            '{FUNC_TICK, 4'd0},       '{FUNC_TICK, 4'd0},       '{FUNC_TICK, 4'd0},
            '{FUNC_START, 4'd0},      '{FUNC_PLAYER_KEY, 4'd8}, '{FUNC_START, 4'd0},
            '{FUNC_LONG_CLR, 4'd0},   '{FUNC_LONG_CLR, 4'd0},   '{FUNC_START, 4'd0},
            '{FUNC_TICK, 4'd0},       '{FUNC_SHORT_CLR, 4'd0},  '{FUNC_LONG_CLR, 4'd0},
            '{FUNC_LONG_CLR, 4'd0},   '{FUNC_SPARE_5, 4'd15},   '{FUNC_SPARE_6, 4'd8},
            '{FUNC_SPARE_7, 4'd0}
        };
        foreach (seq[i])
            send_event(seq[i].func, seq[i].player);
    endtask

    // One quiz round: an optional trip through set mode, then start, ticks until
    // an answer, a timeout or the tick cap, some tone ticks, and a clear.
    task automatic play_round();
        int unsigned steps;
        int unsigned n;
        bit          answer;
        sender_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0)
        begin
            send_event(FUNC_SHORT_CLR, PLAYER_W'($urandom_range(0, 15)));
            send_event(FUNC_LONG_CLR, PLAYER_W'($urandom_range(0, 15)));
            // Sixty or more steps carry the preset through its wrap.
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
            repeat (n)
                send_event(FUNC_START, PLAYER_W'($urandom_range(0, 15)));
            send_event(FUNC_SHORT_CLR, PLAYER_W'($urandom_range(0, 15)));
        end
        send_event(FUNC_START, PLAYER_W'($urandom_range(0, 15)));
        answer = ($urandom_range(0, 1) == 1);
        steps = 0;
        while (sb.armed && !sb.expired && steps < ROUND_TICK_CAP)
        begin
            if ($urandom_range(0, 19) == 0)
                send_noise();
            else if (answer && $urandom_range(0, 15) == 0)
                send_event(FUNC_PLAYER_KEY, PLAYER_W'(($urandom_range(0, 4) == 0)
                           ? $urandom_range(0, 15) : $urandom_range(1, NUM_PLAYERS)));
            else
                send_event(FUNC_TICK, PLAYER_W'($urandom_range(0, 15)));
            steps++;
        end
        repeat ($urandom_range(0, 40))
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_event(FUNC_TICK, PLAYER_W'($urandom_range(0, 15)));
        end
        send_event(($urandom_range(0, 1) == 1) ? FUNC_SHORT_CLR : FUNC_LONG_CLR,
                   PLAYER_W'($urandom_range(0, 15)));
    endtask

    initial
    begin
        int unsigned phase_start;
        sb = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.func   = '0;
        in_ch.player = '0;
        settings_used = 0;
        sender_burst = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        program_regs(16'd1, 16'd3, 16'd0, 16'd0);
        run_directed();

        for (int phase = 1; phase <= RANDOM_PHASES; phase++)
        begin
            case (phase)
                1: program_regs(16'd1, 16'd1, 16'd255, 16'd255);
                2: program_regs(16'd2, 16'd65535, 16'd0, 16'd1);
                3: program_regs(16'd255, 16'd20, 16'd3, 16'd5);
                default: program_regs(CFG_DAT_W'($urandom_range(1, 4)),
                                      CFG_DAT_W'($urandom_range(1, 40)),
                                      CFG_DAT_W'($urandom_range(0, 7)),
                                      CFG_DAT_W'($urandom_range(0, 7)));
            endcase
            phase_start = sb.events;
            while (sb.events - phase_start < ITEMS_PER_PHASE)
                play_round();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d events over %0d register settings: %0d rounds locked by a player,",
                 sb.events, settings_used, sb.locks);
        $display("%0d countdowns ran out, %0d status transactions checked.",
                 sb.timeouts, sb.checked);
        if (sb.mismatches == 0 && sb.pending_status.size() == 0)
            $display("quiz_buzzer_controller: match");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("quiz_buzzer_controller: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/qbc_pkg.sv
rtl/qbc_channels.sv
rtl/quiz_buzzer_controller.sv
tb/sv/tb_quiz_buzzer_controller.sv
